[design/pid_pkg.sv]
// ---------------------------------------------------------------------------
// PID controller package
// Widths, register indexes, reset values and divider sizing shared by the
// channel interfaces and the controller.
// ---------------------------------------------------------------------------
package pid_pkg;

  localparam int VALUE_W = 32;   // signed Q16.16 values and gains
  localparam int STEP_W  = 16;   // unsigned Q0.16 time step
  localparam int FRAC_W  = 16;   // fraction bits of Q16.16

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd3;

  // 1.0 in Q16.16
  localparam logic signed [VALUE_W-1:0] Q_ONE = 32'sh0001_0000;

  localparam logic signed [VALUE_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] S32_MIN = 32'sh8000_0000;

  // Product of two values, and the sum of three shifted products
  localparam int PROD_W = 2 * VALUE_W;
  localparam int TERM_W = PROD_W - FRAC_W;
  localparam int ACC_W  = TERM_W + 2;

  // Derivative divider: |diff| (33 bits) followed by 16 zero bits,
  // padded to an even width and retired two quotient bits per cycle
  localparam int DIFF_W     = VALUE_W + 1;
  localparam int DIV_BITS   = 2;
  localparam int DIVIDEND_W = DIFF_W + FRAC_W + 1;
  localparam int DIV_ITER   = DIVIDEND_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_ITER);

endpackage

[design/pid_if.sv]
// ---------------------------------------------------------------------------
// PID channel interfaces
// Valid/ready channels for the sample word and the result word.
// ---------------------------------------------------------------------------
interface pid_sample_if;
  import pid_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] measurement;
  logic [STEP_W-1:0]         time_step;

  modport source (output valid, measurement, time_step, input ready);
  modport sink   (input valid, measurement, time_step, output ready);
endinterface

interface pid_result_if;
  import pid_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] drive;
  logic                      saturated;

  modport source (output valid, drive, saturated, input ready);
  modport sink   (input valid, drive, saturated, output ready);
endinterface

[design/pid_controller_step.sv]
// ---------------------------------------------------------------------------
// PID controller step
// One control update per sample word: error, saturating integral, derivative
// through a radix-4 restoring divider, and a saturated weighted sum, all on
// one shared 32x32 multiplier under a small sequencer.
// ---------------------------------------------------------------------------
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------
//   sample   | in  | valid / ready | measurement (s32), time_step (u16)
//   result   | out | valid / ready | drive (s32), saturated (1)
//   cfg      | in  | cfg_write     | cfg_index (2), cfg_data (32)
//
// A sample goes through the divider (two quotient bits a cycle) only when
// time_step is nonzero; a zero time_step skips it and forces the derivative
// to zero. The next sample is accepted once the sequencer is back in idle.
// The single multiplier is used four times.
// sample.ready is high only while the sequencer is idle; the result register
// holds a finished word until taken, and a new sample is accepted meanwhile.
// Synchronous reset clears gains to their defaults, the integral and the
// stored error.
// ---------------------------------------------------------------------------
module pid_controller_step (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pid_pkg::VALUE_W-1:0]     cfg_data,
  pid_sample_if.sink                      sample,
  pid_result_if.source                    result
);
  import pid_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERROR,
    S_INT_MUL,
    S_INT_ADD,
    S_DIV,
    S_DERIV,
    S_P_MUL,
    S_I_MUL,
    S_D_MUL,
    S_SUM,
    S_DONE
  } state_t;

  state_t state;

  // configuration
  logic signed [VALUE_W-1:0] gain_p, gain_i, gain_d, target;

  // controller state
  logic signed [VALUE_W-1:0] error_integral, last_error;

  // per-sample working registers
  logic signed [VALUE_W-1:0]  meas, err, deriv;
  logic [STEP_W-1:0]          dt;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic                       clipped;
  logic                       diff_neg;
  logic [DIVIDEND_W-1:0]      div_shift;
  logic [STEP_W-1:0]          div_rem;
  logic [DIV_CNT_W-1:0]       div_cnt;

  // result register
  logic                       out_valid;
  logic signed [VALUE_W-1:0]  out_drive;
  logic                       out_sat;

  // combinational
  logic signed [VALUE_W-1:0]  mul_a, mul_b;
  logic signed [DIFF_W-1:0]   err_wide, int_wide, diff;
  logic signed [VALUE_W-1:0]  err_sat, int_sat, deriv_sat, drive_sat;
  logic                       int_clip, drive_clip;
  logic [DIFF_W-1:0]          diff_mag;
  logic signed [ACC_W-1:0]    term;
  logic [DIVIDEND_W-1:0]      shift_next;
  logic [STEP_W-1:0]          rem_next;
  logic [STEP_W:0]            rem_try;
  logic                       q_pos_ovf, q_neg_ovf;

  assign sample.ready     = (state == S_IDLE);
  assign result.valid     = out_valid;
  assign result.drive     = out_drive;
  assign result.saturated = out_sat;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_INT_MUL: begin
        mul_a = err;
        mul_b = $signed({{(VALUE_W-STEP_W){1'b0}}, dt});
      end
      S_P_MUL: begin
        mul_a = gain_p;
        mul_b = err;
      end
      S_I_MUL: begin
        mul_a = gain_i;
        mul_b = error_integral;
      end
      S_D_MUL: begin
        mul_a = gain_d;
        mul_b = deriv;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    // error = target - measurement, saturated
    err_wide = {target[VALUE_W-1], target} - {meas[VALUE_W-1], meas};
    if (err_wide[DIFF_W-1] != err_wide[DIFF_W-2]) begin
      err_sat = err_wide[DIFF_W-1] ? S32_MIN : S32_MAX;
    end else begin
      err_sat = err_wide[VALUE_W-1:0];
    end

    // integral + floor(err*dt / 2^16), saturated
    int_wide = {error_integral[VALUE_W-1], error_integral}
             + {prod[VALUE_W+FRAC_W-1], prod[VALUE_W+FRAC_W-1:FRAC_W]};
    int_clip = (int_wide[DIFF_W-1] != int_wide[DIFF_W-2]);
    if (int_clip) begin
      int_sat = int_wide[DIFF_W-1] ? S32_MIN : S32_MAX;
    end else begin
      int_sat = int_wide[VALUE_W-1:0];
    end

    // derivative numerator magnitude
    diff     = {err[VALUE_W-1], err} - {last_error[VALUE_W-1], last_error};
    diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // two restoring divide steps
    shift_next = div_shift;
    rem_next   = div_rem;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_try = {rem_next, shift_next[DIVIDEND_W-1]};
      if (rem_try >= {1'b0, dt}) begin
        rem_try    = rem_try - {1'b0, dt};
        shift_next = {shift_next[DIVIDEND_W-2:0], 1'b1};
      end else begin
        shift_next = {shift_next[DIVIDEND_W-2:0], 1'b0};
      end
      rem_next = rem_try[STEP_W-1:0];
    end

    // quotient magnitude to signed, saturated
    q_pos_ovf = (div_shift[DIVIDEND_W-1:VALUE_W-1] != '0);
    q_neg_ovf = (div_shift[DIVIDEND_W-1:VALUE_W] != '0)
              || (div_shift[VALUE_W-1] && (div_shift[VALUE_W-2:0] != '0));
    if (diff_neg) begin
      deriv_sat = q_neg_ovf ? S32_MIN : -$signed(div_shift[VALUE_W-1:0]);
    end else begin
      deriv_sat = q_pos_ovf ? S32_MAX : $signed(div_shift[VALUE_W-1:0]);
    end

    // floor(product / 2^16), sign extended to the accumulator
    term = {{(ACC_W-TERM_W){prod[PROD_W-1]}}, prod[PROD_W-1:FRAC_W]};

    drive_clip = 1'b0;
    drive_sat  = acc[VALUE_W-1:0];
    if (!acc[ACC_W-1] && (acc[ACC_W-2:VALUE_W-1] != '0)) begin
      drive_clip = 1'b1;
      drive_sat  = S32_MAX;
    end else if (acc[ACC_W-1] && (acc[ACC_W-2:VALUE_W-1] != '1)) begin
      drive_clip = 1'b1;
      drive_sat  = S32_MIN;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      gain_p         <= Q_ONE;
      gain_i         <= '0;
      gain_d         <= '0;
      target         <= '0;
      error_integral <= '0;
      last_error     <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GAIN_P: gain_p <= $signed(cfg_data);
          REG_GAIN_I: gain_i <= $signed(cfg_data);
          REG_GAIN_D: gain_d <= $signed(cfg_data);
          REG_TARGET: target <= $signed(cfg_data);
          default: ;
        endcase
      end

      // drop the taken word unless a new one is loaded below
      if (out_valid && result.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            meas  <= sample.measurement;
            dt    <= sample.time_step;
            state <= S_ERROR;
          end
        end
        S_ERROR: begin
          err   <= err_sat;
          state <= S_INT_MUL;
        end
        S_INT_MUL: begin
          // set up the divider, then retire the old error
          diff_neg   <= diff[DIFF_W-1];
          div_shift  <= {1'b0, diff_mag, {FRAC_W{1'b0}}};
          div_rem    <= '0;
          div_cnt    <= '0;
          last_error <= err;
          state      <= S_INT_ADD;
        end
        S_INT_ADD: begin
          error_integral <= int_sat;
          clipped        <= int_clip;
          if (dt == '0) begin
            deriv <= '0;
            state <= S_P_MUL;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          div_shift <= shift_next;
          div_rem   <= rem_next;
          div_cnt   <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_ITER - 1)) begin
            state <= S_DERIV;
          end
        end
        S_DERIV: begin
          deriv <= deriv_sat;
          state <= S_P_MUL;
        end
        S_P_MUL: begin
          state <= S_I_MUL;
        end
        S_I_MUL: begin
          acc   <= term;
          state <= S_D_MUL;
        end
        S_D_MUL: begin
          acc   <= acc + term;
          state <= S_SUM;
        end
        S_SUM: begin
          acc   <= acc + term;
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the result register is free
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_drive <= drive_sat;
            out_sat   <= clipped | drive_clip;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
